/* src/gwm_pkg.sv */
// Package for the glob wildcard matcher: constants, register indexes and
// the pattern configuration struct. No dependencies.
`default_nettype none

package gwm_pkg;

  // Default and absolute limit on pattern characters
  localparam int PATTERN_MAX_DEF = 16;
  localparam int PATTERN_SLOTS   = 16;

  // Special pattern characters and the string terminator
  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;
  localparam logic [7:0] END_CHAR  = 8'h00;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 2'd2;

  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 5;

  typedef logic [7:0] char_t;

  // Pattern as held in the configuration registers
  typedef struct packed {
    logic [PATTERN_SLOTS-1:0][7:0] chars;
    logic [LEN_W-1:0]              length;
  } gwm_pattern_t;

endpackage

`default_nettype wire

/* src/gwm_if.sv */
// Valid/ready channel interfaces for the glob matcher: text bytes in,
// match results out, and configuration writes. Depends on gwm_pkg.
`default_nettype none

interface gwm_in_if;
  logic             valid;
  logic             ready;
  gwm_pkg::char_t   text_char;
  modport source (output valid, output text_char, input ready);
  modport sink   (input valid, input text_char, output ready);
endinterface

interface gwm_out_if;
  logic valid;
  logic ready;
  logic matched;
  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

interface gwm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [gwm_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [gwm_pkg::CFG_DATA_W-1:0]   wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

/* src/gwm_cfg_regs.sv */
// Configuration register bank of the glob matcher: pattern bytes and length.
// Depends on gwm_pkg and gwm_cfg_if.
`default_nettype none

module gwm_cfg_regs (
  input  wire                   clk,
  input  wire                   rst_n,
  gwm_cfg_if.sink               cfg_chan,
  output gwm_pkg::gwm_pattern_t pattern_o
);
  import gwm_pkg::*;

  logic [CFG_DATA_W-1:0] chars_low_r;
  logic [CFG_DATA_W-1:0] chars_high_r;
  logic [LEN_W-1:0]      length_r;
  logic                  wr_en;

  // Writes are always taken; an unknown index is dropped
  assign cfg_chan.ready = 1'b1;
  assign wr_en          = cfg_chan.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_low_r  <= '0;
      chars_high_r <= '0;
      length_r     <= '0;
    end else if (wr_en) begin
      case (cfg_chan.reg_index)
        REG_CHARS_LOW:  chars_low_r  <= cfg_chan.wdata;
        REG_CHARS_HIGH: chars_high_r <= cfg_chan.wdata;
        REG_LENGTH:     length_r     <= cfg_chan.wdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Byte i of the pattern sits in bits 8i+7..8i, low word first
  assign pattern_o.chars  = {chars_high_r, chars_low_r};
  assign pattern_o.length = length_r;

endmodule

`default_nettype wire

/* src/gwm_nfa_step.sv */
// One step of the bit-parallel glob NFA: star closure, byte transition,
// end-of-string match and rearm. Purely combinational. Depends on gwm_pkg.
`default_nettype none

module gwm_nfa_step #(
  parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
  input  gwm_pkg::gwm_pattern_t  pattern_i,
  input  wire [PATTERN_MAX:0]    active_i,
  input  gwm_pkg::char_t         text_char_i,
  output logic [PATTERN_MAX:0]   active_nxt,
  output logic                   matched_o
);
  import gwm_pkg::*;

  localparam int VW     = PATTERN_MAX + 1;
  localparam int LW     = $clog2(VW);
  localparam int LEVELS = $clog2(VW);

  logic [LW-1:0]          eff_len;
  logic [PATTERN_MAX-1:0] star;
  logic [PATTERN_MAX-1:0] hit;
  logic [VW-1:0]          len_mask;
  logic [VW-1:0]          cur_v;
  logic [VW-1:0]          step_v;

  // Star closure as a log-depth prefix: bit j+1 picks up bit j through a star
  function automatic logic [VW-1:0] star_close(input logic [VW-1:0]          v,
                                               input logic [PATTERN_MAX-1:0] st,
                                               input logic [VW-1:0]          msk);
    logic [VW-1:0] g;
    logic [VW-1:0] p;
    logic [VW-1:0] g_n;
    logic [VW-1:0] p_n;
    int            d;
    g = v;
    p = {st, 1'b0};
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      d = 1 << lvl;
      for (int j = 0; j < VW; j++) begin
        if (j >= d) begin
          g_n[j] = g[j] | (p[j] & g[j-d]);
          p_n[j] = p[j] & p[j-d];
        end else begin
          g_n[j] = g[j];
          p_n[j] = 1'b0;
        end
      end
      g = g_n;
      p = p_n;
    end
    return g & msk;
  endfunction

  // Length clamped to the parameter, per-position star and byte match
  always_comb begin
    if (pattern_i.length > LEN_W'(PATTERN_MAX)) begin
      eff_len = LW'(PATTERN_MAX);
    end else begin
      eff_len = pattern_i.length[LW-1:0];
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      star[i] = (pattern_i.chars[i] == STAR_CHAR) && (i < int'(eff_len));
      hit[i]  = !star[i] && (i < int'(eff_len)) &&
                ((pattern_i.chars[i] == ANY_CHAR) || (pattern_i.chars[i] == text_char_i));
    end
    for (int j = 0; j < VW; j++) begin
      len_mask[j] = (j <= int'(eff_len));
    end
  end

  // Transition on one byte: stars hold, matches advance
  always_comb begin
    cur_v  = star_close(active_i, star, len_mask);
    step_v = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      step_v[i]   = step_v[i] | (cur_v[i] & star[i]);
      step_v[i+1] = cur_v[i] & hit[i];
    end
    matched_o = cur_v[eff_len];
    if (text_char_i == END_CHAR) begin
      active_nxt = star_close(VW'(1), star, len_mask);
    end else begin
      active_nxt = star_close(step_v, star, len_mask);
    end
  end

endmodule

`default_nettype wire

/* src/wildcard_glob_match_top.sv */
// Glob wildcard matcher, top level: input register, NFA step, position and result
// registers. Depends on gwm_pkg, gwm_if, gwm_cfg_regs and gwm_nfa_step.
// Throughput: one text byte per cycle through the single NFA step; an end-of-string
// byte waits in the input register only while the previous result is still unread.
// An end-of-string byte moves from the input register through the NFA step into the result register.
// Reset (rst_n, synchronous, active low): pattern cleared, channels emptied, position 0.
`default_nettype none

module wildcard_glob_match_top #(
  parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  gwm_in_if.sink      in_chan,
  gwm_out_if.source   out_chan,
  gwm_cfg_if.sink     cfg_chan
);
  import gwm_pkg::*;

  localparam int VW = PATTERN_MAX + 1;

  gwm_pattern_t  pattern;
  logic          s1_valid_r;
  char_t         s1_char_r;
  logic [VW-1:0] active_r;
  logic [VW-1:0] active_nxt;
  logic          matched_nxt;
  logic          out_valid_r;
  logic          matched_r;
  logic          s1_end;
  logic          s1_adv;
  logic          in_acc;

  gwm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_chan  (cfg_chan),
    .pattern_o (pattern)
  );

  gwm_nfa_step #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_step (
    .pattern_i   (pattern),
    .active_i    (active_r),
    .text_char_i (s1_char_r),
    .active_nxt  (active_nxt),
    .matched_o   (matched_nxt)
  );

  // Held byte moves on unless it ends a string and the result slot is full
  assign s1_end        = (s1_char_r == END_CHAR);
  assign s1_adv        = s1_valid_r && (!s1_end || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      active_r    <= VW'(1);
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv && s1_end) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        active_r <= active_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_chan.text_char;
    end
    if (s1_adv && s1_end) begin
      matched_r <= matched_nxt;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.matched = matched_r;

  // A finished string always lands in the result register
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_end) |=> out_valid_r)
    else $error("end of string did not produce a result");

  // A stalled result is never overwritten by the next string
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !(s1_adv && s1_end))
    else $error("pending result overwritten");

  // Rearm always leaves position zero active
  a_rearm_pos0: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_end) |=> active_r[0])
    else $error("position zero not active after rearm");

  // Backpressure only while a byte is held
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> s1_valid_r)
    else $error("input stalled with empty input register");

endmodule

`default_nettype wire
